>>> rtl/aabb_affine_transform_assert.svh
// Assertion macros for the affine box transform.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef AABB_AFFINE_TRANSFORM_ASSERT_SVH
`define AABB_AFFINE_TRANSFORM_ASSERT_SVH

// Same-cycle implication.
`define AAT_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("aat assertion failed");

// Next-cycle implication.
`define AAT_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("aat assertion failed");

`endif

>>> rtl/aat_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the affine box transform.
// No dependencies.
package aat_pkg;

  localparam int DATA_W            = 32;
  localparam int NUM_COEFF         = 12;
  localparam int COEFF_IDX_W       = 4;
  localparam int NUM_AXES          = 3;
  localparam int DEF_COORD_WIDTH   = 32;
  localparam int DEF_FRAC_BITS     = 16;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_XFORM = 1'b1
  } aat_kind_e;

  typedef logic signed [DATA_W-1:0] aat_word_t;

  // One classified item between front and back
  typedef struct packed {
    aat_kind_e                 kind;
    logic [COEFF_IDX_W-1:0]    idx;
    aat_word_t                 value;
    aat_word_t [NUM_AXES-1:0]  lo;
    aat_word_t [NUM_AXES-1:0]  hi;
    logic                      empty;
  } aat_item_t;

  typedef struct packed {
    logic      valid;
    aat_item_t item;
  } aat_link_t;

endpackage

>>> rtl/aat_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for item input and box output.
// Depends on aat_pkg.
interface aat_in_if import aat_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [COEFF_IDX_W-1:0] coeff_index;
  logic signed [DATA_W-1:0] coeff_value;
  logic signed [DATA_W-1:0] min_x;
  logic signed [DATA_W-1:0] min_y;
  logic signed [DATA_W-1:0] min_z;
  logic signed [DATA_W-1:0] max_x;
  logic signed [DATA_W-1:0] max_y;
  logic signed [DATA_W-1:0] max_z;

  modport source (output valid, operation, coeff_index, coeff_value,
                  min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, operation, coeff_index, coeff_value,
                  min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface aat_out_if import aat_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_min_x;
  logic signed [DATA_W-1:0] out_min_y;
  logic signed [DATA_W-1:0] out_min_z;
  logic signed [DATA_W-1:0] out_max_x;
  logic signed [DATA_W-1:0] out_max_y;
  logic signed [DATA_W-1:0] out_max_z;
  logic                     input_was_empty;

  modport source (output valid, out_min_x, out_min_y, out_min_z,
                  out_max_x, out_max_y, out_max_z, input_was_empty, input ready);
  modport sink   (input valid, out_min_x, out_min_y, out_min_z,
                  out_max_x, out_max_y, out_max_z, input_was_empty, output ready);
endinterface

>>> rtl/aat_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on aat_pkg and aat_in_if.
module aat_front import aat_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  aat_in_if.sink    in_i,
  output aat_link_t link_o,
  input  logic      pop_i
);

  aat_item_t q_mem [2];
  logic      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  aat_item_t item;
  logic       push, xfer, pop;

  always_comb begin
    item.kind  = aat_kind_e'(in_i.operation);
    item.idx   = in_i.coeff_index;
    item.value = in_i.coeff_value;
    item.lo    = {in_i.min_z, in_i.min_y, in_i.min_x};
    item.hi    = {in_i.max_z, in_i.max_y, in_i.max_x};
    item.empty = (in_i.min_x > in_i.max_x) || (in_i.min_y > in_i.max_y) ||
                 (in_i.min_z > in_i.max_z);
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign xfer       = in_i.valid && in_i.ready;
  // loads beyond the last coefficient are dropped here
  assign push = xfer && ((item.kind == KIND_XFORM) ||
                         (item.idx < COEFF_IDX_W'(NUM_COEFF)));
  assign pop  = pop_i && (cnt_q != 2'd0);

  assign link_o.valid = (cnt_q != 2'd0);
  assign link_o.item  = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item;
    end
  end

endmodule

>>> rtl/aat_back.sv
`timescale 1ns / 1ps
// Back end: matrix store, corner products, row sums and saturation.
// Depends on aat_pkg, aat_out_if and the assertion macro header.
`include "aabb_affine_transform_assert.svh"
module aat_back import aat_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  aat_link_t link_i,
  output logic      pop_o,
  aat_out_if.source out_o
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int TR_W   = DATA_W + FRAC_BITS;
  localparam int SUM_W  = ((TR_W > PROD_W) ? TR_W : PROD_W) + 3;
  localparam int SAT_W  = (COORD_WIDTH > DATA_W) ? DATA_W : COORD_WIDTH;

  aat_word_t matrix_q [NUM_COEFF];

  logic adv;
  logic s1_valid_q, s1_empty_q, s2_valid_q, s2_empty_q, out_valid_q;
  logic signed [PROD_W-1:0] pmin_d [NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0] pmax_d [NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0] pmin_q [NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0] pmax_q [NUM_AXES][NUM_AXES];
  aat_word_t                tr_q   [NUM_AXES];
  logic signed [SUM_W-1:0]  smin_d [NUM_AXES];
  logic signed [SUM_W-1:0]  smax_d [NUM_AXES];
  logic signed [SUM_W-1:0]  smin_q [NUM_AXES];
  logic signed [SUM_W-1:0]  smax_q [NUM_AXES];
  aat_word_t                omin_d [NUM_AXES];
  aat_word_t                omax_d [NUM_AXES];
  aat_word_t                omin_q [NUM_AXES];
  aat_word_t                omax_q [NUM_AXES];
  logic                     oempty_q;
  logic                     is_load, is_xform;

  // the whole pipe moves together when the output slot frees up
  assign adv      = !out_valid_q || out_o.ready;
  assign pop_o    = adv;
  assign is_load  = link_i.valid && (link_i.item.kind == KIND_LOAD);
  assign is_xform = link_i.valid && (link_i.item.kind == KIND_XFORM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // identity: diagonal entries sit where row equals column
      for (int i = 0; i < NUM_COEFF; i++) begin
        matrix_q[i] <= ((i >> 2) == (i & 3)) ? (DATA_W'(1) << FRAC_BITS) : '0;
      end
    end else if (adv && is_load) begin
      matrix_q[link_i.item.idx] <= link_i.item.value;
    end
  end

  // Per column the sign of the coefficient picks which corner minimizes.
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        if (matrix_q[r * 4 + c][DATA_W-1]) begin
          pmin_d[r][c] = matrix_q[r * 4 + c] * link_i.item.hi[c];
          pmax_d[r][c] = matrix_q[r * 4 + c] * link_i.item.lo[c];
        end else begin
          pmin_d[r][c] = matrix_q[r * 4 + c] * link_i.item.lo[c];
          pmax_d[r][c] = matrix_q[r * 4 + c] * link_i.item.hi[c];
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      smin_d[r] = (SUM_W'(tr_q[r]) <<< FRAC_BITS) + SUM_W'(pmin_q[r][0]) +
                  SUM_W'(pmin_q[r][1]) + SUM_W'(pmin_q[r][2]);
      smax_d[r] = (SUM_W'(tr_q[r]) <<< FRAC_BITS) + SUM_W'(pmax_q[r][0]) +
                  SUM_W'(pmax_q[r][1]) + SUM_W'(pmax_q[r][2]);
    end
  end

  // floor shift, then clamp to the saturation width
  function automatic aat_word_t sat_shift(logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] sh;
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    hi_lim = (SUM_W'(1) <<< (SAT_W - 1)) - SUM_W'(1);
    lo_lim = -(SUM_W'(1) <<< (SAT_W - 1));
    sh     = s >>> FRAC_BITS;
    if (sh > hi_lim) begin
      sh = hi_lim;
    end else if (sh < lo_lim) begin
      sh = lo_lim;
    end
    return sh[DATA_W-1:0];
  endfunction

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      omin_d[r] = s2_empty_q ? '0 : sat_shift(smin_q[r]);
      omax_d[r] = s2_empty_q ? '0 : sat_shift(smax_q[r]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= is_xform;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_empty_q <= link_i.item.empty;
      s2_empty_q <= s1_empty_q;
      oempty_q   <= s2_empty_q;
      for (int r = 0; r < NUM_AXES; r++) begin
        tr_q[r]   <= matrix_q[r * 4 + 3];
        smin_q[r] <= smin_d[r];
        smax_q[r] <= smax_d[r];
        omin_q[r] <= omin_d[r];
        omax_q[r] <= omax_d[r];
        for (int c = 0; c < NUM_AXES; c++) begin
          pmin_q[r][c] <= pmin_d[r][c];
          pmax_q[r][c] <= pmax_d[r][c];
        end
      end
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.out_min_x       = omin_q[0];
  assign out_o.out_min_y       = omin_q[1];
  assign out_o.out_min_z       = omin_q[2];
  assign out_o.out_max_x       = omax_q[0];
  assign out_o.out_max_y       = omax_q[1];
  assign out_o.out_max_z       = omax_q[2];
  assign out_o.input_was_empty = oempty_q;

  `AAT_ASSERT_NXT(a_load_no_result, adv && is_load, !s1_valid_q)
  `AAT_ASSERT_IMP(a_empty_zero, out_valid_q && oempty_q, (omin_q[0] == '0) && (omax_q[2] == '0))
  `AAT_ASSERT_IMP(a_box_order, out_valid_q && !oempty_q, (omin_q[0] <= omax_q[0]) && (omin_q[1] <= omax_q[1]) && (omin_q[2] <= omax_q[2]))

endmodule

>>> rtl/aabb_affine_transform.sv
`timescale 1ns / 1ps
// Affine box transform. An input transfer passes through the queue, the product
// register and the sum register, then saturates into the output register.
// Throughput: one item per cycle while the output is taken. Loads
// give no result. The product stage holds 18 multipliers of 32 by 32 bits.
// Reset loads the identity matrix and empties the queue and pipeline.
module aabb_affine_transform import aat_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aat_in_if.sink    in_i,
  aat_out_if.source out_o
);

  aat_link_t link;
  logic      pop;

  aat_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .link_o (link),
    .pop_i  (pop)
  );

  aat_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .link_i (link),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

>>> sim/aabb_affine_transform_checker.sv
`timescale 1ns / 1ps
// Checker for the affine box transform: watches both channels, predicts each
// transformed box and compares it field by field. Depends on aat_pkg, aat_if.
module aabb_affine_transform_checker import aat_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  aat_in_if     in_mon,
  aat_out_if    out_mon,
  output int    fail_count_o
);

  typedef struct packed {
    aat_word_t [NUM_AXES-1:0] bmin;
    aat_word_t [NUM_AXES-1:0] bmax;
    logic                     empty;
  } box_result_t;

  aat_word_t   coeff [NUM_COEFF];
  box_result_t pending_boxes[$];
  int          fails;

  assign fail_count_o = fails;

  function automatic void load_identity();
    foreach (coeff[i]) coeff[i] = '0;
    coeff[0]  = 32'sd1 <<< DEF_FRAC_BITS;
    coeff[5]  = 32'sd1 <<< DEF_FRAC_BITS;
    coeff[10] = 32'sd1 <<< DEF_FRAC_BITS;
  endfunction

  // Exact sum, floor shift, then clamp to 32-bit signed range
  function automatic aat_word_t row_coord(int r, logic signed [63:0] x,
                                          logic signed [63:0] y,
                                          logic signed [63:0] z);
    logic signed [127:0] acc;
    acc = 128'(coeff[r*4]) * 128'(x) + 128'(coeff[r*4+1]) * 128'(y)
        + 128'(coeff[r*4+2]) * 128'(z)
        + (128'(coeff[r*4+3]) <<< DEF_FRAC_BITS);
    acc = acc >>> DEF_FRAC_BITS;
    if (acc > 128'sd2147483647) return 32'sh7fffffff;
    if (acc < -128'sd2147483648) return 32'sh80000000;
    return acc[31:0];
  endfunction

  function automatic box_result_t transform_box(aat_word_t lo[3], aat_word_t hi[3]);
    box_result_t res;
    aat_word_t   v;
    res = '0;
    if (lo[0] > hi[0] || lo[1] > hi[1] || lo[2] > hi[2]) begin
      res.empty = 1'b1;
      return res;
    end
    for (int k = 0; k < 8; k++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        v = row_coord(a, k[0] ? hi[0] : lo[0], k[1] ? hi[1] : lo[1],
                      k[2] ? hi[2] : lo[2]);
        if (k == 0 || v < res.bmin[a]) res.bmin[a] = v;
        if (k == 0 || v > res.bmax[a]) res.bmax[a] = v;
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    load_identity();
  end

  always @(posedge clk_i) begin
    aat_word_t   lo[3], hi[3];
    box_result_t exp_box;
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == KIND_LOAD) begin
          if (in_mon.coeff_index < NUM_COEFF) coeff[in_mon.coeff_index] = in_mon.coeff_value;
        end else begin
          lo = '{in_mon.min_x, in_mon.min_y, in_mon.min_z};
          hi = '{in_mon.max_x, in_mon.max_y, in_mon.max_z};
          pending_boxes.push_back(transform_box(lo, hi));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_boxes.size() == 0) begin
          $error("box result with no transform pending");
          fails++;
        end else begin
          exp_box = pending_boxes.pop_front();
          check_field("out_min_x", exp_box.bmin[0], out_mon.out_min_x);
          check_field("out_min_y", exp_box.bmin[1], out_mon.out_min_y);
          check_field("out_min_z", exp_box.bmin[2], out_mon.out_min_z);
          check_field("out_max_x", exp_box.bmax[0], out_mon.out_max_x);
          check_field("out_max_y", exp_box.bmax[1], out_mon.out_max_y);
          check_field("out_max_z", exp_box.bmax[2], out_mon.out_max_z);
          check_field("input_was_empty", 32'(exp_box.empty), 32'(out_mon.input_was_empty));
        end
      end
    end
  end

  function automatic int boxes_pending();
    return pending_boxes.size();
  endfunction

endmodule

>>> sim/aabb_affine_transform_test.sv
`timescale 1ns / 1ps
// Top of the affine box transform bench: clock, reset, item stimulus, result
// stalls and verdict. Depends on aat_pkg, aat_if, the checker and the block.
module aabb_affine_transform_test;
  import aat_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   idle_cycles = 0;
  bit   hold_sink = 1'b0;

  aat_in_if  items();
  aat_out_if boxes();

  aabb_affine_transform DUT (.clk_i, .rst_ni, .in_i(items), .out_o(boxes));
  aabb_affine_transform_checker checker_inst (.clk_i, .rst_ni, .in_mon(items),
                                              .out_mon(boxes),
                                              .fail_count_o(fail_count));

  always #5 clk_i = ~clk_i;

  // Corner-heavy value draw
  function automatic aat_word_t pick_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      4: return $signed($urandom_range(0, 32'h7fffff)) - 32'sh400000;
      default: return $urandom();
    endcase
  endfunction

  function automatic aat_word_t pick_coeff();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh10000;
      2: return '0;
      default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    endcase
  endfunction

  // Called at a falling edge; valid stays up into the next item unless a gap is drawn
  task automatic send_item(aat_kind_e kind, logic [3:0] idx, aat_word_t val,
                           aat_word_t lx, aat_word_t ly, aat_word_t lz,
                           aat_word_t hx, aat_word_t hy, aat_word_t hz, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 18) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      items.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    items.valid <= 1'b1;
    items.operation <= kind;
    items.coeff_index <= idx;
    items.coeff_value <= val;
    items.min_x <= lx; items.min_y <= ly; items.min_z <= lz;
    items.max_x <= hx; items.max_y <= hy; items.max_z <= hz;
    do @(posedge clk_i); while (!items.ready);
    @(negedge clk_i);
  endtask

  task automatic send_box(aat_word_t lx, aat_word_t ly, aat_word_t lz,
                          aat_word_t hx, aat_word_t hy, aat_word_t hz, bit gaps);
    send_item(KIND_XFORM, 4'($urandom()), $urandom(), lx, ly, lz, hx, hy, hz, gaps);
  endtask

  task automatic send_load(logic [3:0] idx, aat_word_t val, bit gaps);
    send_item(KIND_LOAD, idx, val, $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), gaps);
  endtask

  task automatic send_ordered_box(bit gaps);
    aat_word_t a[6];
    foreach (a[i]) a[i] = pick_word();
    if ($urandom_range(0, 9) == 0) begin
      send_box(a[0], a[1], a[2], a[3], a[4], a[5], gaps);
    end else begin
      send_box(a[0] < a[3] ? a[0] : a[3], a[1] < a[4] ? a[1] : a[4],
               a[2] < a[5] ? a[2] : a[5], a[0] < a[3] ? a[3] : a[0],
               a[1] < a[4] ? a[4] : a[1], a[2] < a[5] ? a[5] : a[2], gaps);
    end
  endtask

  // Receiver stalls; one long hold-off while the sender keeps offering
  initial begin
    int wait_n;
    boxes.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        boxes.ready <= 1'b0;
        repeat (150) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      if ($urandom_range(0, 2) == 0) begin
        wait_n = $urandom_range(0, 18);
        if (wait_n > 0) begin
          boxes.ready <= 1'b0;
          repeat (wait_n) @(negedge clk_i);
        end
      end
      boxes.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((items.valid && items.ready) || (boxes.valid && boxes.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    items.valid = 1'b0;
    items.operation = KIND_LOAD;
    items.coeff_index = '0;
    items.coeff_value = '0;
    items.min_x = '0; items.min_y = '0; items.min_z = '0;
    items.max_x = '0; items.max_y = '0; items.max_z = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: identity, extremes, empty boxes, loads, ignored index, overflow
    send_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_box(-32'sh10000, 32'sh0, 32'sh5, 32'sh10000, 32'sh0, 32'sh5, 1'b0);
    send_box(32'sh1, 0, 0, 32'sh0, 0, 0, 1'b0);
    send_box(0, 0, 32'sh7fffffff, 0, 0, 32'sh80000000, 1'b0);
    send_box(0, 32'sh1, 0, 0, 32'sh0, 0, 1'b0);
    send_load(4'd15, 32'sh7fffffff, 1'b0);
    send_load(4'd12, 32'sh80000000, 1'b0);
    send_box(-32'sh1, -32'sh1, -32'sh1, 32'sh1, 32'sh1, 32'sh1, 1'b0);
    send_load(4'd0, 32'sh7fffffff, 1'b0);
    send_load(4'd1, 32'sh80000000, 1'b0);
    send_load(4'd3, 32'sh7fffffff, 1'b0);
    send_load(4'd7, 32'sh80000000, 1'b0);
    send_load(4'd11, -32'sh18000, 1'b0);
    send_load(4'd6, 32'sh8000, 1'b0);
    send_box(32'sh80000000, -32'sh3, 32'sh0, 32'sh7fffffff, 32'sh7, 32'sh1, 1'b0);
    send_box(-32'sh1, -32'sh1, -32'sh1, -32'sh1, -32'sh1, -32'sh1, 1'b0);
    for (int i = 0; i < NUM_COEFF; i++) send_load(i[3:0], pick_coeff(), 1'b0);

    // Random: mostly boxes with fresh coefficients now and then
    for (int n = 0; n < 1000; n++) begin
      if (n == 300) hold_sink = 1'b1;
      if ($urandom_range(0, 4) == 0) send_load(4'($urandom_range(0, 15)), pick_coeff(), 1'b1);
      else send_ordered_box(n < 300 || n > 420);
    end
    items.valid <= 1'b0;

    while (checker_inst.boxes_pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
